@@ hw/rtl/olist_pkg.sv @@
// olist_pkg: shared types and constants for the ordered list engine
// request kinds, result status codes, sequencer states and default sizes
// no dependencies
package olist_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int LENGTH_W  = 7;

    localparam int IN_TDATA_W  = 40;  // value + position, padded to bytes
    localparam int IN_TUSER_W  = 8;   // kind, padded to bytes
    localparam int OUT_TDATA_W = 48;  // removed_value + status + length

    typedef enum logic [KIND_W-1:0] {
        K_APPEND    = 2'd0,
        K_REM_HEAD  = 2'd1,
        K_REM_AT    = 2'd2,
        K_SWAP      = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_SHIFT,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C,
        S_FIN
    } t_state;

endpackage

@@ hw/rtl/olist_ram.sv @@
// olist_ram: generic single-write, single-read memory with registered read data
// no dependencies
module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
// ordered_list_engine: append, remove-head, remove-at and swap on a bounded list
// throughput: one request at a time; removals are bound by the single memory port pair,
//   which moves one entry per cycle
// reset: synchronous active low, empties the list; entry memory is not cleared
// depends on olist_pkg and olist_ram
module ordered_list_engine
    import olist_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] value, [37:32] position, rest zero
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // [1:0] kind, rest zero
    // result channel
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [31:0] removed_value, [33:32] status,
                                                // [40:34] length, rest zero
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > LENGTH_W) ? CW : LENGTH_W;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_addr,  n_addr;
    logic [DATA_WIDTH-1:0]  r_tmp,   n_tmp;
    logic [VALUE_W-1:0]     r_removed, n_removed;
    t_status                r_status,  n_status;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DATA_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DATA_WIDTH-1:0]  ram_rdata;

    t_kind                  in_kind;
    logic [VALUE_W-1:0]     in_value;
    logic [POS_W-1:0]       in_pos;
    logic [XW-1:0]          pos_x;
    logic [XW-1:0]          at_x;
    logic [XW-1:0]          count_x;
    logic [XW-1:0]          addr_x;
    logic [63:0]            in_ext;
    logic [63:0]            rd_ext;
    logic                   s_accept;

    assign in_kind  = t_kind'(i_s_tuser[KIND_W-1:0]);
    assign in_value = i_s_tdata[VALUE_W-1:0];
    assign in_pos   = i_s_tdata[VALUE_W +: POS_W];
    assign pos_x    = XW'(in_pos);
    assign at_x     = (in_kind == K_REM_HEAD) ? '0 : pos_x;
    assign count_x  = XW'(r_count);
    assign addr_x   = XW'(r_addr);
    assign in_ext   = 64'($signed(in_value));
    assign rd_ext   = 64'($signed(ram_rdata));

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    olist_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_tmp      <= n_tmp;
        r_removed  <= n_removed;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_tmp       = r_tmp;
        n_removed   = r_removed;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_state   = S_FIN;
                    unique case (in_kind)
                        K_APPEND: begin
                            if (count_x >= XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = in_ext[DATA_WIDTH-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        K_REM_HEAD, K_REM_AT: begin
                            if (at_x >= count_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                // read the victim now, data lands next cycle
                                ram_raddr = AW'(at_x);
                                n_addr    = AW'(at_x);
                                n_state   = S_REM;
                            end
                        end
                        K_SWAP: begin
                            if (pos_x + XW'(1) >= count_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                ram_raddr = AW'(pos_x);
                                n_addr    = AW'(pos_x);
                                n_state   = S_SWAP_A;
                            end
                        end
                    endcase
                end
            end
            S_REM: begin
                n_removed = rd_ext[VALUE_W-1:0];
                if (addr_x + XW'(1) < count_x) begin
                    ram_raddr = AW'(addr_x + XW'(1));
                    n_state   = S_SHIFT;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                // entry r_addr+1 arrives, move it down one slot
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = ram_rdata;
                if (addr_x + XW'(2) < count_x) begin
                    ram_raddr = AW'(addr_x + XW'(2));
                    n_addr    = AW'(addr_x + XW'(1));
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_SWAP_A: begin
                n_tmp     = ram_rdata;
                ram_raddr = AW'(addr_x + XW'(1));
                n_state   = S_SWAP_B;
            end
            S_SWAP_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = ram_rdata;
                n_state   = S_SWAP_C;
            end
            S_SWAP_C: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(addr_x + XW'(1));
                ram_wdata = r_tmp;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {
                        (OUT_TDATA_W - VALUE_W - STATUS_W - LENGTH_W)'(0),
                        LENGTH_W'(r_count),
                        r_status,
                        r_removed
                    };
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ sim/tb_ordered_list_engine.sv @@
// tb_ordered_list_engine: self-checking testbench for the ordered list engine
// directed list cases, then random request traffic checked against a queue-based list model
// depends on olist_pkg and the ordered_list_engine rtl
module tb_ordered_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import olist_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    typedef struct packed {
        logic [VALUE_W-1:0]  removed;
        t_status             status;
        logic [LENGTH_W-1:0] length;
    } t_list_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;  // [31:0] value, [37:32] position, rest zero
    logic [IN_TUSER_W-1:0]  i_s_tuser  = '0;  // [1:0] kind, rest zero
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // [31:0] removed_value, [33:32] status,
                                              // [40:34] length, rest zero

    int                    send_idle_pct = 31;
    int                    recv_idle_pct = 55;
    int                    error_count   = 0;
    logic signed [31:0]    list_model[$];
    t_list_result          pending_results[$];
    t_list_result          seen_result;
    t_list_result          wanted_result;

    ordered_list_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // applies one request to the list model and returns the result it should produce
    function automatic t_list_result apply_request(t_kind kind, logic signed [31:0] value,
                                                   logic [POS_W-1:0] pos);
        t_list_result       r;
        int                 at;
        logic signed [31:0] held;
        r.removed = '0;
        r.status  = ST_OK;
        case (kind)
            K_APPEND: begin
                if (list_model.size() >= CAP) r.status = ST_FULL;
                else list_model.push_back(value);
            end
            K_REM_HEAD, K_REM_AT: begin
                at = (kind == K_REM_HEAD) ? 0 : int'(pos);
                if (at >= list_model.size()) begin
                    r.status = ST_RANGE;
                end else begin
                    r.removed = list_model[at];
                    list_model.delete(at);
                end
            end
            default: begin
                if (int'(pos) + 1 >= list_model.size()) begin
                    r.status = ST_RANGE;
                end else begin
                    held                = list_model[pos];
                    list_model[pos]     = list_model[pos + 1];
                    list_model[pos + 1] = held;
                end
            end
        endcase
        r.length = LENGTH_W'(list_model.size());
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly an index inside the current list, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(t_kind kind);
        int n;
        n = list_model.size();
        if ($urandom_range(4) == 0) return POS_W'($urandom_range(63));
        if (kind == K_SWAP) return (n >= 2) ? POS_W'($urandom_range(n - 2))
                                            : POS_W'($urandom_range(63));
        return (n >= 1) ? POS_W'($urandom_range(n - 1)) : POS_W'($urandom_range(63));
    endfunction

    task automatic send_request(input t_kind kind, input logic [31:0] value,
                                input logic [POS_W-1:0] pos);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, pos, value};
        i_s_tuser  = {6'b000000, kind};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(apply_request(kind, value, pos));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_request(K_REM_HEAD, 32'h1234_5678, 6'd0);
        send_request(K_REM_AT,   32'h0,         6'd0);
        send_request(K_REM_AT,   32'hffff_ffff, 6'd63);
        send_request(K_SWAP,     32'h0,         6'd0);
    endtask

    task automatic test_append_extremes();
        send_request(K_APPEND, 32'h7fff_ffff, 6'd63);
        send_request(K_APPEND, 32'h8000_0000, 6'd0);
        send_request(K_APPEND, 32'h0000_0000, 6'd21);
        send_request(K_APPEND, 32'hffff_ffff, 6'd42);
        send_request(K_APPEND, 32'h5a5a_a5a5, 6'd0);
    endtask

    task automatic test_swap();
        send_request(K_SWAP, 32'h0, 6'd0);
        send_request(K_SWAP, 32'h0, 6'd3);
        // last entry has no successor
        send_request(K_SWAP, 32'h0, 6'd4);
        send_request(K_SWAP, 32'h0, 6'd63);
    endtask

    task automatic test_remove_at();
        send_request(K_REM_AT, 32'h0, 6'd2);
        send_request(K_REM_AT, 32'h0, 6'd3);
        send_request(K_REM_AT, 32'h0, 6'd3);
        send_request(K_REM_AT, 32'h0, 6'd63);
    endtask

    task automatic test_remove_head();
        repeat (4) send_request(K_REM_HEAD, $urandom, POS_W'($urandom_range(63)));
    endtask

    task automatic test_full_list();
        while (list_model.size() < CAP) send_request(K_APPEND, pick_value(), pick_position(K_APPEND));
        send_request(K_APPEND, pick_value(), 6'd0);
        send_request(K_APPEND, pick_value(), 6'd63);
        send_request(K_SWAP,   32'h0, POS_W'(CAP - 2));
        send_request(K_SWAP,   32'h0, POS_W'(CAP - 1));
        // removing at index 0 of a full list moves every entry behind it
        send_request(K_REM_AT, 32'h0, 6'd0);
        send_request(K_APPEND, pick_value(), 6'd0);
        send_request(K_REM_AT, 32'h0, POS_W'(CAP - 1));
        send_request(K_REM_HEAD, 32'h0, 6'd0);
    endtask

    // bursts lean toward appends or removals so the list swings between empty and full
    task automatic test_random_traffic(input int count);
        int    burst;
        int    append_pct;
        t_kind kind;
        burst      = 0;
        append_pct = 50;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(120, 20);
                case ($urandom_range(2))
                    0:       append_pct = 85;
                    1:       append_pct = 50;
                    default: append_pct = 15;
                endcase
            end
            burst--;
            if ($urandom_range(99) < append_pct) kind = K_APPEND;
            else kind = t_kind'($urandom_range(3, 1));
            send_request(kind, pick_value(), pick_position(kind));
        end
    endtask

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_result.removed = o_m_tdata[31:0];
            seen_result.status  = t_status'(o_m_tdata[33:32]);
            seen_result.length  = o_m_tdata[40:34];
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result beat with no request pending: %h", $realtime,
                             o_m_tdata);
            end else begin
                wanted_result = pending_results.pop_front();
                if (seen_result !== wanted_result) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: mismatch removed exp %h got %h, status exp %0d got %0d, length exp %0d got %0d",
                                 $realtime, wanted_result.removed, seen_result.removed,
                                 wanted_result.status, seen_result.status,
                                 wanted_result.length, seen_result.length);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_append_extremes();
        test_swap();
        test_remove_at();
        test_remove_head();
        wait_for_results();
        test_full_list();
        test_random_traffic(400);
        wait_for_results();

        send_idle_pct = 55;
        recv_idle_pct = 31;
        test_random_traffic(430);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(430);
        wait_for_results();

        // room for a stray beat after the longest shift
        repeat (CAP + 20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
